@@ design/slr_pkg.sv @@
package slr_pkg;

  localparam int unsigned NumWeightsDef   = 65536;
  localparam int unsigned MaxFeaturesDef  = 64;
  localparam int unsigned SigDepthDef     = 256;
  localparam int unsigned WaddrW          = 24;
  localparam logic [15:0] LearnRateRst    = 16'd410;
  localparam logic [16:0] ProbHalf        = 17'd32768;

  typedef struct packed {
    logic               req_type;
    logic [15:0]        feature_id;
    logic signed [23:0] feature_value;
    logic               label;
    logic               last_feature;
  } slr_in_t;

  typedef struct packed {
    logic [16:0] probability;
    logic        predicted_label;
    logic        mispredicted;
    logic [31:0] error_count;
    logic        buffer_overflow;
  } slr_out_t;

  typedef struct packed {
    logic              we;
    logic [WaddrW-1:0] addr;
    logic [31:0]       wdata;
  } slr_wreq_t;

  typedef enum logic [8:0] {
    S_CLR = 9'b000000001,
    S_IN  = 9'b000000010,
    S_MUL = 9'b000000100,
    S_ACC = 9'b000001000,
    S_SIG = 9'b000010000,
    S_RES = 9'b000100000,
    S_RD  = 9'b001000000,
    S_WRD = 9'b010000000,
    S_WUP = 9'b100000000
  } slr_state_e;

  // floor(n / d) by shift and subtract, used only to build tables
  function automatic longint unsigned udiv_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-f in Q32 for f in Q16, 0 <= f <= 1.0, truncated Taylor series
  function automatic longint unsigned exp_neg_frac(longint unsigned f);
    longint unsigned term;
    longint          sum;
    term = 64'd1 << 32;
    sum  = longint'(term);
    for (int unsigned k = 1; k <= 16; k++) begin
      term = udiv_u64((term * f) >> 16, 64'(k));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // e^-a in Q32 for a in Q16, 0 <= a <= 8.0
  function automatic longint unsigned exp_neg(longint unsigned a);
    longint unsigned r;
    longint unsigned e1;
    longint unsigned n;
    n  = a >> 16;
    r  = exp_neg_frac(a & 64'hFFFF);
    e1 = exp_neg_frac(64'd65536);
    for (longint unsigned j = 0; j < n; j++) begin
      r = (r * e1) >> 32;
    end
    return r;
  endfunction

endpackage

@@ design/slr_wmem.sv @@
module slr_wmem import slr_pkg::*; #(
  parameter int unsigned NUM_WEIGHTS = NumWeightsDef,
  parameter int unsigned AW          = $clog2(NUM_WEIGHTS)
) (
  input  logic        clk_i,
  input  slr_wreq_t   req_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem [NUM_WEIGHTS];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr[AW-1:0]] <= req_i.wdata;
    end
    rdata_o <= mem[req_i.addr[AW-1:0]];
  end

endmodule

@@ design/slr_fbuf.sv @@
module slr_fbuf import slr_pkg::*; #(
  parameter int unsigned DEPTH = MaxFeaturesDef,
  parameter int unsigned BW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int unsigned AW    = 16
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [BW-1:0]      waddr_i,
  input  logic [AW-1:0]      wid_i,
  input  logic signed [23:0] wval_i,
  input  logic [BW-1:0]      raddr_i,
  output logic [AW-1:0]      rid_o,
  output logic signed [23:0] rval_o
);

  logic [AW-1:0]      id_mem  [DEPTH];
  logic signed [23:0] val_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_mem[waddr_i]  <= wid_i;
      val_mem[waddr_i] <= wval_i;
    end
    rid_o  <= id_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end

endmodule

@@ design/slr_sig.sv @@
module slr_sig import slr_pkg::*; #(
  parameter int unsigned SIGMOID_TABLE_DEPTH = SigDepthDef
) (
  input  logic               clk_i,
  input  logic signed [47:0] acc_i,
  output logic [16:0]        prob_o
);

  localparam int unsigned TW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned SW = 21 + $clog2(SIGMOID_TABLE_DEPTH + 1);

  logic [16:0]        tab [SIGMOID_TABLE_DEPTH];
  logic signed [47:0] zc;
  logic [20:0]        zu;
  logic [SW-1:0]      scaled;
  logic [SW-21:0]     idx_raw;
  logic [TW-1:0]      idx;

  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_tab
    localparam longint          X   = (longint'(g) * 64'sd1048576) / SIGMOID_TABLE_DEPTH
                                      - 64'sd524288;
    localparam longint unsigned A   = (X < 0) ? longint'(-X) : longint'(X);
    localparam longint unsigned DEN = (64'd1 << 32) + exp_neg(A);
    localparam longint unsigned PP  = ((64'd1 << 48) + DEN / 2) / DEN;
    localparam longint unsigned ENT = (X < 0) ? (64'd65536 - PP) : PP;
    assign tab[g] = ENT[16:0];
  end

  // clamp to +/-8.0 and scale onto the table
  always_comb begin
    if (acc_i > 48'sd524288)       zc = 48'sd524288;
    else if (acc_i < -48'sd524288) zc = -48'sd524288;
    else                           zc = acc_i;
    zu      = 21'(zc + 48'sd524288);
    scaled  = SW'(zu) * SW'(SIGMOID_TABLE_DEPTH);
    idx_raw = scaled[SW-1:20];
    if (idx_raw >= (SW-20)'(SIGMOID_TABLE_DEPTH)) idx = TW'(SIGMOID_TABLE_DEPTH - 1);
    else                                           idx = idx_raw[TW-1:0];
  end

  always_ff @(posedge clk_i) begin
    prob_o <= tab[idx];
  end

endmodule

@@ design/sparse_logistic_regression_sgd_top.sv @@
// channel  | direction | handshake                 | word
// in       | input     | in_valid_i / in_ready_o   | slr_in_t, one sparse feature
// out      | output    | out_valid_o / out_ready_i | slr_out_t, one per sample
// cfg      | input     | cfg_valid_i / cfg_ready_o | learning rate, Q4.12
//
// A feature that is not last passes S_IN (weight read), then S_MUL (multiply).
// The last feature adds S_ACC, S_SIG and S_RES (accumulate, sigmoid lookup, result);
// a train sample then passes S_RD, S_WRD and S_WUP per buffered feature on the
// single-port weight memory (read, multiply, write back). After reset a clearing pass
// writes NUM_WEIGHTS zero words, one per cycle, before the first word is taken.
// The result register frees the pipe once loaded; a stall holds only the next result.
module sparse_logistic_regression_sgd_top import slr_pkg::*; #(
  parameter int unsigned NUM_WEIGHTS         = NumWeightsDef,
  parameter int unsigned MAX_SAMPLE_FEATURES = MaxFeaturesDef,
  parameter int unsigned SIGMOID_TABLE_DEPTH = SigDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  slr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output slr_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_WEIGHTS);
  localparam int unsigned CW = $clog2(MAX_SAMPLE_FEATURES + 1);
  localparam int unsigned BW = (MAX_SAMPLE_FEATURES > 1) ? $clog2(MAX_SAMPLE_FEATURES) : 1;

  slr_state_e         state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               ovf_q, ovf_d;
  logic signed [47:0] acc_q, acc_d;
  logic               prod_vld_q, prod_vld_d;
  logic [31:0]        mist_q, mist_d;
  logic [15:0]        lr_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic [CW-1:0]      upd_n_q, upd_n_d;
  logic [CW-1:0]      upd_i_q, upd_i_d;
  logic               out_vld_q, out_vld_d;

  logic signed [23:0] fval_q;
  logic               req_q, label_q, last_q;
  logic signed [55:0] prod_q;
  logic signed [34:0] coef_q;
  logic signed [58:0] upd_prod_q;
  logic [AW-1:0]      widx_q;
  slr_out_t           out_q;

  logic               in_fire;
  logic               room;
  logic               load_out;
  logic [WaddrW-1:0]  wid_in;
  slr_wreq_t          wreq;
  logic [31:0]        wrdata;
  logic [AW-1:0]      fb_rid;
  logic signed [23:0] fb_rval;
  logic [16:0]        prob;
  logic               pred, mis;
  logic [31:0]        mist_new;
  logic signed [17:0] diff;
  logic signed [48:0] acc_sum;
  logic signed [31:0] addend;
  logic signed [38:0] step;
  logic signed [39:0] wsum;
  logic [31:0]        wnew;

  // weight index modulo NUM_WEIGHTS
  if (NUM_WEIGHTS >= 65536) begin : g_id_wide
    assign wid_in = WaddrW'(in_data_i.feature_id);
  end else if ((NUM_WEIGHTS & (NUM_WEIGHTS - 1)) == 0) begin : g_id_pow2
    assign wid_in = WaddrW'(in_data_i.feature_id[AW-1:0]);
  end else begin : g_id_recip
    localparam longint unsigned Recip = (64'd1 << 32) / NUM_WEIGHTS;
    logic [47:0] qf;
    logic [15:0] q;
    logic [31:0] r;
    always_comb begin
      qf = 48'(in_data_i.feature_id) * 48'(Recip);
      q  = qf[47:32];
      r  = 32'(in_data_i.feature_id) - 32'(q) * 32'(NUM_WEIGHTS);
      if (r >= 32'(NUM_WEIGHTS)) r = r - 32'(NUM_WEIGHTS);
    end
    assign wid_in = WaddrW'(r);
  end

  assign in_ready_o  = (state_q == S_IN);
  assign in_fire     = in_valid_i && in_ready_o;
  assign room        = cnt_q < CW'(MAX_SAMPLE_FEATURES);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign load_out    = (state_q == S_RES) && (!out_vld_q || out_ready_i);

  slr_wmem #(.NUM_WEIGHTS(NUM_WEIGHTS), .AW(AW)) u_wmem (
    .clk_i   (clk_i),
    .req_i   (wreq),
    .rdata_o (wrdata)
  );

  slr_fbuf #(.DEPTH(MAX_SAMPLE_FEATURES), .BW(BW), .AW(AW)) u_fbuf (
    .clk_i   (clk_i),
    .we_i    (in_fire && room),
    .waddr_i (cnt_q[BW-1:0]),
    .wid_i   (wid_in[AW-1:0]),
    .wval_i  (in_data_i.feature_value),
    .raddr_i (upd_i_q[BW-1:0]),
    .rid_o   (fb_rid),
    .rval_o  (fb_rval)
  );

  slr_sig #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
    .clk_i  (clk_i),
    .acc_i  (acc_q),
    .prob_o (prob)
  );

  always_comb begin
    addend  = prod_q[55:24];
    acc_sum = $signed({acc_q[47], acc_q}) + $signed({{17{addend[31]}}, addend});
    step    = upd_prod_q[58:20];
    wsum    = $signed({{8{wrdata[31]}}, wrdata}) + $signed({step[38], step});
    if (wsum > 40'sd2147483647)       wnew = 32'h7FFF_FFFF;
    else if (wsum < -40'sd2147483648) wnew = 32'h8000_0000;
    else                              wnew = wsum[31:0];
    pred     = (prob >= ProbHalf);
    mis      = (pred != label_q);
    mist_new = (req_q && mis && (mist_q != 32'hFFFF_FFFF)) ? mist_q + 32'd1 : mist_q;
    diff     = $signed({1'b0, label_q, 16'b0}) - $signed({1'b0, prob});
  end

  always_comb begin
    wreq.we    = 1'b0;
    wreq.addr  = wid_in;
    wreq.wdata = 32'd0;
    case (state_q)
      S_CLR: begin
        wreq.we   = 1'b1;
        wreq.addr = WaddrW'(clr_q);
      end
      S_WRD: wreq.addr = WaddrW'(fb_rid);
      S_WUP: begin
        wreq.we    = 1'b1;
        wreq.addr  = WaddrW'(widx_q);
        wreq.wdata = wnew;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ovf_d      = ovf_q;
    acc_d      = acc_q;
    prod_vld_d = prod_vld_q;
    mist_d     = mist_q;
    clr_d      = clr_q;
    upd_n_d    = upd_n_q;
    upd_i_d    = upd_i_q;
    out_vld_d  = out_vld_q;

    if (out_vld_q && out_ready_i) out_vld_d = 1'b0;

    // fold the pending product into the saturating accumulator
    if (prod_vld_q) begin
      prod_vld_d = 1'b0;
      if (acc_sum[48] != acc_sum[47]) begin
        acc_d = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
        acc_d = acc_sum[47:0];
      end
    end

    case (state_q)
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(NUM_WEIGHTS - 1)) state_d = S_IN;
      end
      S_IN: begin
        if (in_fire) begin
          if (room) begin
            cnt_d   = cnt_q + CW'(1);
            state_d = S_MUL;
          end else begin
            ovf_d = 1'b1;
            if (in_data_i.last_feature) state_d = S_ACC;
          end
        end
      end
      S_MUL: begin
        prod_vld_d = 1'b1;
        state_d    = last_q ? S_ACC : S_IN;
      end
      S_ACC: state_d = S_SIG;
      S_SIG: state_d = S_RES;
      S_RES: begin
        if (load_out) begin
          out_vld_d = 1'b1;
          mist_d    = mist_new;
          upd_n_d   = cnt_q;
          upd_i_d   = '0;
          acc_d     = '0;
          cnt_d     = '0;
          ovf_d     = 1'b0;
          state_d   = (!req_q && (cnt_q != '0)) ? S_RD : S_IN;
        end
      end
      S_RD:  state_d = S_WRD;
      S_WRD: state_d = S_WUP;
      S_WUP: begin
        upd_i_d = upd_i_q + CW'(1);
        state_d = ((upd_i_q + CW'(1)) == upd_n_q) ? S_IN : S_RD;
      end
      default: state_d = S_IN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      cnt_q      <= '0;
      ovf_q      <= 1'b0;
      acc_q      <= '0;
      prod_vld_q <= 1'b0;
      mist_q     <= '0;
      lr_q       <= LearnRateRst;
      clr_q      <= '0;
      upd_n_q    <= '0;
      upd_i_q    <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      ovf_q      <= ovf_d;
      acc_q      <= acc_d;
      prod_vld_q <= prod_vld_d;
      mist_q     <= mist_d;
      clr_q      <= clr_d;
      upd_n_q    <= upd_n_d;
      upd_i_q    <= upd_i_d;
      out_vld_q  <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) lr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      fval_q  <= in_data_i.feature_value;
      req_q   <= in_data_i.req_type;
      label_q <= in_data_i.label;
      last_q  <= in_data_i.last_feature;
    end
    if (state_q == S_MUL) prod_q <= fval_q * $signed(wrdata);
    if (load_out) begin
      out_q.probability     <= prob;
      out_q.predicted_label <= pred;
      out_q.mispredicted    <= mis;
      out_q.error_count     <= mist_new;
      out_q.buffer_overflow <= ovf_q;
      coef_q                <= diff * $signed({1'b0, lr_q});
    end
    if (state_q == S_WRD) begin
      upd_prod_q <= fb_rval * coef_q;
      widx_q     <= fb_rid;
    end
  end

  a_clr_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_ready_o)
    else $error("word taken during clearing pass");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_SAMPLE_FEATURES))
    else $error("buffer count beyond depth");

  a_res_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && state_d != S_RES) |=> out_vld_q)
    else $error("result left without a loaded word");

  a_upd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WUP) |-> (upd_i_q < upd_n_q))
    else $error("update index past buffered count");

  a_pred_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.predicted_label == (out_q.probability >= ProbHalf)))
    else $error("predicted label disagrees with probability");

endmodule

@@ tb/testbench.sv @@
module testbench;
  import slr_pkg::*;

  localparam logic REQ_TRAIN   = 1'b0;
  localparam logic REQ_PREDICT = 1'b1;
  localparam int   IDLE_WAIT   = 400;
  localparam int   WDOG_LIMIT  = 200000;

  // Fixed-point model of the sparse SGD classifier and its pending results.
  class slr_predictor;
    int               wts [NumWeightsDef];
    logic [15:0]      ids [MaxFeaturesDef];
    longint           vals [MaxFeaturesDef];
    longint           dot_acc;
    int               n_buf;
    bit               ovf;
    logic [31:0]      mistakes;
    logic [15:0]      rate;
    logic [16:0]      sig_tab [SigDepthDef];
    slr_out_t         pending_results [$];
    int               errors;

    function new();
      longint           x;
      longint unsigned  a, den, pp;
      foreach (wts[i]) wts[i] = 0;
      dot_acc  = 0;
      n_buf    = 0;
      ovf      = 0;
      mistakes = 0;
      rate     = LearnRateRst;
      errors   = 0;
      for (int i = 0; i < SigDepthDef; i++) begin
        x   = longint'((longint'(i) * 1048576) / SigDepthDef) - 524288;
        a   = (x < 0) ? -x : x;
        den = (64'd1 << 32) + exp_q32(a);
        pp  = ((64'd1 << 48) + den / 2) / den;
        sig_tab[i] = (x < 0) ? 17'(65536 - pp) : 17'(pp);
      end
    endfunction

    // Taylor series for e^-f, f in Q16 at most one
    function longint unsigned taylor_q32(longint unsigned f);
      longint unsigned term;
      longint          sum;
      term = 64'd1 << 32;
      sum  = longint'(term);
      for (int k = 1; k <= 16; k++) begin
        term = ((term * f) >> 16) / k;
        if (k % 2 == 1) sum -= longint'(term);
        else            sum += longint'(term);
      end
      return (sum < 0) ? 0 : sum;
    endfunction

    function longint unsigned exp_q32(longint unsigned a);
      longint unsigned r, e1;
      r  = taylor_q32(a & 64'hFFFF);
      e1 = taylor_q32(65536);
      for (longint unsigned j = 0; j < (a >> 16); j++) r = (r * e1) >> 32;
      return r;
    endfunction

    function int sat_word(longint v);
      if (v > 64'sd2147483647) return 32'h7FFFFFFF;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
    endfunction

    function void note_feature(slr_in_t d);
      longint      fv, z, diff;
      int          idx;
      logic [16:0] prob;
      logic        pred, mis;
      slr_out_t    r;
      fv = longint'(d.feature_value);
      if (n_buf < MaxFeaturesDef) begin
        dot_acc += (fv * longint'(wts[d.feature_id])) >>> 24;
        if (dot_acc > 64'sd140737488355327) dot_acc = 64'sd140737488355327;
        if (dot_acc < -64'sd140737488355328) dot_acc = -64'sd140737488355328;
        ids[n_buf]  = d.feature_id;
        vals[n_buf] = fv;
        n_buf++;
      end else begin
        ovf = 1;
      end
      if (!d.last_feature) return;
      z = dot_acc;
      if (z > 524288) z = 524288;
      if (z < -524288) z = -524288;
      idx = int'((z + 524288) >>> 12);
      if (idx > SigDepthDef - 1) idx = SigDepthDef - 1;
      prob = sig_tab[idx];
      pred = (prob >= ProbHalf);
      mis  = (pred != d.label);
      if (d.req_type == REQ_PREDICT) begin
        if (mis && mistakes != 32'hFFFFFFFF) mistakes++;
      end else begin
        diff = longint'(d.label) * 65536 - longint'(prob);
        for (int i = 0; i < n_buf; i++)
          wts[ids[i]] = sat_word(longint'(wts[ids[i]]) +
                                 ((vals[i] * diff * longint'(rate)) >>> 20));
      end
      r.probability     = prob;
      r.predicted_label = pred;
      r.mispredicted    = mis;
      r.error_count     = mistakes;
      r.buffer_overflow = ovf;
      pending_results = {pending_results, r};
      dot_acc = 0;
      n_buf   = 0;
      ovf     = 0;
    endfunction

    function void check_result(slr_out_t got);
      slr_out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got.probability != want.probability ||
          got.predicted_label != want.predicted_label ||
          got.mispredicted != want.mispredicted ||
          got.error_count != want.error_count ||
          got.buffer_overflow != want.buffer_overflow) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: prob %0d/%0d pred %0b/%0b mis %0b/%0b cnt %0d/%0d ovf %0b/%0b",
                   want.probability, got.probability, want.predicted_label,
                   got.predicted_label, want.mispredicted, got.mispredicted,
                   want.error_count, got.error_count, want.buffer_overflow,
                   got.buffer_overflow);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  slr_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  slr_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  slr_predictor model = new();
  int           src_idle_pct = 0;
  int           snk_stall_pct = 0;
  bit           hold_request = 0;
  int           quiet_cycles = 0;

  always #10 clk_i = ~clk_i;

  sparse_logistic_regression_sgd_top dut (.*);

  // receiver: check accepted words, then pick next ready
  always @(posedge clk_i) begin
    int hold_left;
    if (out_valid_o && out_ready_i) model.check_result(out_data_o);
    if (hold_request) begin
      hold_request = 0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_feature(logic rt, logic [15:0] fid, logic [23:0] fv,
                              logic lbl, logic last);
    slr_in_t d;
    int      gap;
    d.req_type      = rt;
    d.feature_id    = fid;
    d.feature_value = fv;
    d.label         = lbl;
    d.last_feature  = last;
    gap = 0;
    while ($urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    model.note_feature(d);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_rate(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.rate  = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [23:0] pick_value();
    case ($urandom_range(5))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return 24'($signed($urandom_range(262143)) - 131072);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_id();
    if ($urandom_range(9) < 7) return 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  // one sample; mixed selects a random mode per word, the last decides
  task automatic send_sample(int nfeat, bit mixed, output int sent);
    logic rt, lbl;
    rt  = 1'($urandom_range(1));
    lbl = 1'($urandom_range(1));
    for (int i = 0; i < nfeat; i++)
      send_feature(mixed ? logic'($urandom_range(1)) : rt, pick_id(), pick_value(),
                   lbl, i == nfeat - 1);
    sent = nfeat;
  endtask

  initial begin
    int done_items, n;
    logic [15:0] rates [8];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_rate(16'd410);
    // extremes of value and id, both modes, mixed modes
    send_feature(REQ_TRAIN, 16'd0, 24'h7FFFFF, 1'b1, 1'b0);
    send_feature(REQ_TRAIN, 16'hFFFF, 24'h800000, 1'b1, 1'b1);
    send_feature(REQ_TRAIN, 16'd0, 24'h7FFFFF, 1'b0, 1'b0);
    send_feature(REQ_TRAIN, 16'd0, 24'h7FFFFF, 1'b0, 1'b1);
    send_feature(REQ_PREDICT, 16'd0, 24'h7FFFFF, 1'b1, 1'b1);
    send_feature(REQ_PREDICT, 16'hFFFF, 24'h000001, 1'b0, 1'b1);
    send_feature(REQ_PREDICT, 16'd5, 24'h000000, 1'b0, 1'b1);
    send_feature(REQ_PREDICT, 16'd7, 24'h010000, 1'b1, 1'b0);
    send_feature(REQ_TRAIN, 16'd7, 24'hFF0000, 1'b1, 1'b1);
    send_feature(REQ_TRAIN, 16'd9, 24'h020000, 1'b1, 1'b0);
    send_feature(REQ_TRAIN, 16'd9, 24'h020000, 1'b1, 1'b0);
    send_feature(REQ_PREDICT, 16'd9, 24'h020000, 1'b1, 1'b1);
    send_feature(REQ_PREDICT, 16'hAAAA, 24'h555555, 1'b0, 1'b1);
    send_feature(REQ_TRAIN, 16'h5555, 24'hAAAAAA, 1'b1, 1'b1);

    rates[0] = 16'd0;
    rates[1] = 16'hFFFF;
    rates[2] = 16'd410;
    rates[3] = 16'd1;
    for (int p = 4; p < 8; p++) rates[p] = 16'($urandom);
    done_items = 0;
    for (int p = 0; p < 8; p++) begin
      write_rate(rates[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 55; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 55; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      if (p == 4) hold_request = 1;
      n = 0;
      while (n < 160) begin
        case ($urandom_range(19))
          0:       send_sample($urandom_range(65, 70), 0, done_items);
          1:       send_sample(64, 0, done_items);
          2, 3:    send_sample($urandom_range(1, 6), 1, done_items);
          default: send_sample($urandom_range(1, 8), 0, done_items);
        endcase
        n += done_items;
      end
    end

    drain();
    if (model.errors == 0 && model.pending_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
